// File: src/prac_pkg.sv
package prac_pkg;

   localparam int CoordW = 32;
   localparam int AngW = 16;
   localparam int WideW = 36;
   localparam int CorW = 33;
   localparam int PhW = 35;
   localparam int ScW = 16;
   localparam int ScFrac = 14;
   localparam int PhShift = 18;
   localparam int CordicSteps = 20;
   localparam int StepW = 5;
   localparam int PrdW = WideW + ScW;
   localparam int IdxW = 3;
   localparam int NumAng = 3;

   localparam logic [IdxW-1:0] RegAngX = 3'd0;
   localparam logic [IdxW-1:0] RegAngY = 3'd1;
   localparam logic [IdxW-1:0] RegAngZ = 3'd2;
   localparam logic [IdxW-1:0] RegPivX = 3'd3;
   localparam logic [IdxW-1:0] RegPivY = 3'd4;
   localparam logic [IdxW-1:0] RegPivZ = 3'd5;

   localparam logic signed [PhW-1:0] PhPi = 35'sd3373259426;
   localparam logic signed [PhW-1:0] PhHalfPi = 35'sd1686629713;
   localparam logic signed [CorW-1:0] CordicX0 = 33'sd652032874;
   localparam logic signed [ScW-1:0] ScOne = 16'sd16384;

   typedef struct packed {
      logic signed [CorW-1:0] x;
      logic signed [CorW-1:0] y;
      logic signed [PhW-1:0] z;
      logic flip;
   } prac_cordic_type;

   typedef struct packed {
      logic signed [WideW-1:0] u;
      logic signed [WideW-1:0] v;
      logic signed [WideW-1:0] w;
   } prac_point_type;

   typedef struct packed {
      logic signed [ScW-1:0] s;
      logic signed [ScW-1:0] c;
   } prac_sc_type;

   // Truncated atan(2^-i) in Q30.
   function automatic logic signed [PhW-1:0] atan_q30(input logic [StepW-1:0] i);
      logic signed [PhW-1:0] r;
      case (i)
         5'd0: r = 35'sd843314856;
         5'd1: r = 35'sd497837829;
         5'd2: r = 35'sd263043836;
         5'd3: r = 35'sd133525158;
         5'd4: r = 35'sd67021686;
         5'd5: r = 35'sd33543515;
         5'd6: r = 35'sd16775850;
         5'd7: r = 35'sd8388437;
         5'd8: r = 35'sd4194282;
         5'd9: r = 35'sd2097149;
         5'd10: r = 35'sd1048575;
         5'd11: r = 35'sd524287;
         5'd12: r = 35'sd262143;
         5'd13: r = 35'sd131071;
         5'd14: r = 35'sd65535;
         5'd15: r = 35'sd32767;
         5'd16: r = 35'sd16383;
         5'd17: r = 35'sd8191;
         5'd18: r = 35'sd4095;
         5'd19: r = 35'sd2047;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: src/prac_cordic_cell.sv
module prac_cordic_cell (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [prac_pkg::StepW-1:0]  step,
   input  prac_pkg::prac_cordic_type   d,
   output prac_pkg::prac_cordic_type   q
);
   import prac_pkg::*;

   prac_cordic_type q_ff, q_in;

   // One rotation-mode step; both shifts use the incoming x and y.
   always_comb begin
      q_in = d;
      if (!d.z[PhW-1]) begin
         q_in.x = d.x - (d.y >>> step);
         q_in.y = d.y + (d.x >>> step);
         q_in.z = d.z - atan_q30(step);
      end else begin
         q_in.x = d.x + (d.y >>> step);
         q_in.y = d.y - (d.x >>> step);
         q_in.z = d.z + atan_q30(step);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: src/prac_turn_cell.sv
module prac_turn_cell (
   input  logic                      clock,
   input  logic                      enable,
   input  prac_pkg::prac_sc_type     sc,
   input  prac_pkg::prac_point_type  d,
   output prac_pkg::prac_point_type  q
);
   import prac_pkg::*;

   // Rotates (u, v) by the angle in sc and passes w along; two register stages.
   logic signed [PrdW-1:0] uc_ff, us_ff, vc_ff, vs_ff;
   logic signed [PrdW-1:0] uc_in, us_in, vc_in, vs_in;
   logic signed [WideW-1:0] w_ff;
   logic signed [PrdW:0] su, sv, su_sh, sv_sh;
   prac_point_type q_ff, q_in;

   assign uc_in = d.u * sc.c;
   assign us_in = d.u * sc.s;
   assign vc_in = d.v * sc.c;
   assign vs_in = d.v * sc.s;

   always_comb begin
      su = uc_in[PrdW-1] ? '0 : '0;
      su = $signed({uc_ff[PrdW-1], uc_ff}) - $signed({vs_ff[PrdW-1], vs_ff})
           + $signed((PrdW+1)'(1 << (ScFrac - 1)));
      sv = $signed({vc_ff[PrdW-1], vc_ff}) + $signed({us_ff[PrdW-1], us_ff})
           + $signed((PrdW+1)'(1 << (ScFrac - 1)));
      su_sh = su >>> ScFrac;
      sv_sh = sv >>> ScFrac;
      q_in.u = su_sh[WideW-1:0];
      q_in.v = sv_sh[WideW-1:0];
      q_in.w = w_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         uc_ff <= uc_in;
         us_ff <= us_in;
         vc_ff <= vc_in;
         vs_ff <= vs_in;
         w_ff  <= d.w;
         q_ff  <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: src/point_rotate_about_center.sv
// Rotates one Q16.16 point per transaction about a configured center point.
// The request channel (req_) carries x, y and z; the response channel (rsp_)
// returns the rotated point with each coordinate saturated to 32 bits.
// The csr_ channel writes the three Q3.12 angles and the center; it is always
// ready. The user must write it only while no transaction is in flight; the
// block does not enforce this. The point is offset by the center, rotated
// about Z, then Y, then X, and moved back. Sine and cosine for each
// transaction come out of a row of 20 CORDIC cells per angle that runs beside
// the point. One transaction is taken every cycle while no response is held;
// a transaction passes the entry registers, the row of CORDIC cells, the six
// multiply and sum stages of the three rotations and the response register.
// The whole pipeline advances together: when a response is held because
// rsp_tready is low, req_tready drops and every stage keeps its contents.
// A request can still be taken while a response waits as long as the
// response register is being drained.
// Reset clears the configuration registers to zero (no rotation, center at the
// origin) and empties the pipeline.
module point_rotate_about_center (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [95:0]                  req_tdata,  // in_x, in_y, in_z
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [95:0]                  rsp_tdata,  // out_x, out_y, out_z
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [prac_pkg::IdxW-1:0]    csr_index,
   input  logic [31:0]                  csr_data
);
   import prac_pkg::*;

   // Stage positions in the valid line.
   localparam int StRound = CordicSteps + 1;
   localparam int StLast = StRound + 6;

   logic signed [AngW-1:0] ang_ff [NumAng];
   logic signed [CoordW-1:0] piv_ff [NumAng];
   logic signed [CoordW-1:0] in_c [NumAng];

   logic enable;
   logic [StLast:0] vld_ff, vld_in;
   logic rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff, rsp_tdata_in;

   prac_cordic_type cor_w [NumAng][CordicSteps+1];
   prac_cordic_type cor_in [NumAng];
   prac_cordic_type cor0_ff [NumAng];
   prac_sc_type sc_ff [NumAng];
   prac_sc_type sc_in [NumAng];
   prac_point_type pt_ff [StRound+1];
   prac_point_type pt_in;
   prac_point_type tz_in, tz_out, ty_in, ty_out, tx_in, tx_out;

   assign csr_ready = 1'b1;
   assign enable = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = enable;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumAng; k++) begin
            ang_ff[k] <= '0;
            piv_ff[k] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            RegAngX: ang_ff[0] <= csr_data[AngW-1:0];
            RegAngY: ang_ff[1] <= csr_data[AngW-1:0];
            RegAngZ: ang_ff[2] <= csr_data[AngW-1:0];
            RegPivX: piv_ff[0] <= csr_data;
            RegPivY: piv_ff[1] <= csr_data;
            RegPivZ: piv_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Entry stage: offset the point and fold each angle into +/- pi/2.
   always_comb begin
      logic signed [PhW-1:0] ph;
      logic fl;
      for (int k = 0; k < NumAng; k++) begin
         in_c[k] = req_tdata[k*CoordW +: CoordW];
         ph = {ang_ff[k][AngW-1], ang_ff[k], {PhShift{1'b0}}};
         fl = 1'b0;
         for (int r = 0; r < 3; r++) begin
            if (ph > PhHalfPi) begin
               ph = ph - PhPi;
               fl = !fl;
            end else if (ph < -PhHalfPi) begin
               ph = ph + PhPi;
               fl = !fl;
            end
         end
         cor_in[k].x = CordicX0;
         cor_in[k].y = '0;
         cor_in[k].z = ph;
         cor_in[k].flip = fl;
      end
      pt_in.u = WideW'(in_c[0]) - WideW'(piv_ff[0]);
      pt_in.v = WideW'(in_c[1]) - WideW'(piv_ff[1]);
      pt_in.w = WideW'(in_c[2]) - WideW'(piv_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cor0_ff <= cor_in;
         pt_ff[0] <= pt_in;
         for (int i = 1; i <= StRound; i++) begin
            pt_ff[i] <= pt_ff[i-1];
         end
      end
   end

   // Row of CORDIC cells, one row per angle.
   for (genvar k = 0; k < NumAng; k++) begin : g_ang
      assign cor_w[k][0] = cor0_ff[k];
      for (genvar i = 0; i < CordicSteps; i++) begin : g_step
         prac_cordic_cell u_cell (
            .clock  (clock),
            .enable (enable),
            .step   (StepW'(i)),
            .d      (cor_w[k][i]),
            .q      (cor_w[k][i+1])
         );
      end
   end

   // Round the CORDIC outputs to Q1.14, clamp to one and undo the fold.
   always_comb begin
      logic signed [CorW:0] vc, vs;
      logic signed [CorW:0] rc, rs;
      for (int k = 0; k < NumAng; k++) begin
         vc = (CorW+1)'(cor_w[k][CordicSteps].x) + (CorW+1)'(32768);
         vs = (CorW+1)'(cor_w[k][CordicSteps].y) + (CorW+1)'(32768);
         rc = vc >>> 16;
         rs = vs >>> 16;
         if (rc > (CorW+1)'(ScOne)) rc = (CorW+1)'(ScOne);
         if (rc < -(CorW+1)'(ScOne)) rc = -(CorW+1)'(ScOne);
         if (rs > (CorW+1)'(ScOne)) rs = (CorW+1)'(ScOne);
         if (rs < -(CorW+1)'(ScOne)) rs = -(CorW+1)'(ScOne);
         if (cor_w[k][CordicSteps].flip) begin
            rc = -rc;
            rs = -rs;
         end
         sc_in[k].c = rc[ScW-1:0];
         sc_in[k].s = rs[ScW-1:0];
      end
   end

   // All transactions in flight share one configuration, so one held copy
   // of the factors serves the three rotation stages.
   always_ff @(posedge clock) begin
      if (enable && vld_ff[StRound-1]) begin
         sc_ff <= sc_in;
      end
   end

   // About Z: rotate (x, y), carry z.
   assign tz_in = pt_ff[StRound];
   prac_turn_cell u_turn_z (
      .clock (clock), .enable (enable), .sc (sc_ff[2]), .d (tz_in), .q (tz_out)
   );

   // About Y: rotate (x, z), carry y.
   assign ty_in.u = tz_out.u;
   assign ty_in.v = tz_out.w;
   assign ty_in.w = tz_out.v;
   prac_turn_cell u_turn_y (
      .clock (clock), .enable (enable), .sc (sc_ff[1]), .d (ty_in), .q (ty_out)
   );

   // About X: rotate (y, z), carry x.
   assign tx_in.u = ty_out.w;
   assign tx_in.v = ty_out.v;
   assign tx_in.w = ty_out.u;
   prac_turn_cell u_turn_x (
      .clock (clock), .enable (enable), .sc (sc_ff[0]), .d (tx_in), .q (tx_out)
   );

   // Move back by the center and saturate.
   always_comb begin
      logic signed [WideW:0] sum;
      logic signed [WideW-1:0] crd [NumAng];
      crd[0] = tx_out.w;
      crd[1] = tx_out.u;
      crd[2] = tx_out.v;
      for (int k = 0; k < NumAng; k++) begin
         sum = (WideW+1)'(crd[k]) + (WideW+1)'(piv_ff[k]);
         if (sum > (WideW+1)'(32'sh7FFFFFFF)) begin
            rsp_tdata_in[k*CoordW +: CoordW] = 32'h7FFFFFFF;
         end else if (sum < (WideW+1)'(-33'sh080000000)) begin
            rsp_tdata_in[k*CoordW +: CoordW] = 32'h80000000;
         end else begin
            rsp_tdata_in[k*CoordW +: CoordW] = sum[CoordW-1:0];
         end
      end
   end

   assign vld_in = {vld_ff[StLast-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= vld_in;
         rsp_tvalid_ff <= vld_ff[StLast];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   // A held response freezes the whole pipeline, including the input side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while a response is held");

   // A transaction leaving the last rotation stage becomes a response.
   assert property (@(posedge clock) disable iff (reset)
      enable && vld_ff[StLast] |=> rsp_tvalid_ff)
      else $error("transaction lost at the output register");

   // The rounded factors never exceed one in magnitude; the check covers the X cosine and the Y sine.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[StRound] |-> (sc_ff[0].c <= ScOne && sc_ff[0].c >= -ScOne &&
                           sc_ff[1].s <= ScOne && sc_ff[1].s >= -ScOne))
      else $error("sine or cosine out of range");

endmodule
